/* design/slbs_pkg.sv */
// Shared types, codes and lookup tables for the status light and buzzer sequencer.
package slbs_pkg;

  // Flight state codes
  localparam logic [2:0] FS_BOOT    = 3'd0;
  localparam logic [2:0] FS_IDLE    = 3'd1;
  localparam logic [2:0] FS_ARMED   = 3'd2;
  localparam logic [2:0] FS_TAKEOFF = 3'd3;
  localparam logic [2:0] FS_FLYING  = 3'd4;
  localparam logic [2:0] FS_RTL     = 3'd5;
  localparam logic [2:0] FS_LANDING = 3'd6;
  localparam logic [2:0] FS_ERROR   = 3'd7;

  // Battery level codes
  localparam logic [1:0] BATT_NORMAL = 2'd0;
  localparam logic [1:0] BATT_WARN   = 2'd1;
  localparam logic [1:0] BATT_CRIT   = 2'd2;

  // Buzzer pattern codes
  localparam logic [3:0] PAT_NONE     = 4'd0;
  localparam logic [3:0] PAT_BOOT     = 4'd1;
  localparam logic [3:0] PAT_ARM      = 4'd2;
  localparam logic [3:0] PAT_DISARM   = 4'd3;
  localparam logic [3:0] PAT_TAKEOFF  = 4'd4;
  localparam logic [3:0] PAT_RTL      = 4'd5;
  localparam logic [3:0] PAT_LAND     = 4'd6;
  localparam logic [3:0] PAT_LOWBATT  = 4'd7;
  localparam logic [3:0] PAT_CRITICAL = 4'd8;

  // Blink periods in ms, stored as half periods
  localparam int unsigned PeriodCrit  = 125;
  localparam int unsigned PeriodFast  = 250;
  localparam int unsigned PeriodMid   = 500;
  localparam int unsigned PeriodSlow  = 1000;
  localparam int unsigned HalfW       = 9;
  localparam logic [HalfW-1:0] HALF_CRIT = HalfW'(PeriodCrit / 2);
  localparam logic [HalfW-1:0] HALF_FAST = HalfW'(PeriodFast / 2);
  localparam logic [HalfW-1:0] HALF_MID  = HalfW'(PeriodMid / 2);
  localparam logic [HalfW-1:0] HALF_SLOW = HalfW'(PeriodSlow / 2);

  localparam int unsigned DurW = 13;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [2:0]  flight_state;
    logic [1:0]  batt_warn;
    logic        start_pattern;
    logic [3:0]  pattern_id;
  } sl_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       buzzer_on;
  } sl_out_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    rgb_t             rgb;
    logic             blink;
    logic [HalfW-1:0] half_period;
  } light_mode_t;

  typedef struct packed {
    logic [DurW-1:0] dur;
    logic            on;
  } tone_step_t;

  // Colour and blink rate; battery alarm overrides the flight state
  function automatic light_mode_t pick_mode(logic [2:0] st, logic [1:0] bw);
    light_mode_t m;
    m.rgb         = '{red: 8'd255, green: 8'd0, blue: 8'd0};
    m.blink       = 1'b0;
    m.half_period = HALF_SLOW;
    case (bw)
      BATT_CRIT: begin
        m.rgb = '{red: 8'd255, green: 8'd0, blue: 8'd0};
        m.blink = 1'b1;
        m.half_period = HALF_CRIT;
      end
      BATT_WARN: begin
        m.rgb = '{red: 8'd255, green: 8'd80, blue: 8'd0};
        m.blink = 1'b1;
        m.half_period = HALF_FAST;
      end
      default: begin
        case (st)
          FS_BOOT: m.rgb = '{red: 8'd200, green: 8'd200, blue: 8'd200};
          FS_IDLE: m.rgb = '{red: 8'd60, green: 8'd100, blue: 8'd255};
          FS_ARMED: begin
            m.rgb = '{red: 8'd0, green: 8'd255, blue: 8'd60};
            m.blink = 1'b1;
            m.half_period = HALF_SLOW;
          end
          FS_TAKEOFF, FS_FLYING: begin
            m.rgb = '{red: 8'd0, green: 8'd255, blue: 8'd60};
            m.blink = 1'b1;
            m.half_period = HALF_FAST;
          end
          FS_RTL: begin
            m.rgb = '{red: 8'd255, green: 8'd140, blue: 8'd0};
            m.blink = 1'b1;
            m.half_period = HALF_MID;
          end
          FS_LANDING: begin
            m.rgb = '{red: 8'd255, green: 8'd140, blue: 8'd0};
            m.blink = 1'b1;
            m.half_period = HALF_SLOW;
          end
          default: m.rgb = '{red: 8'd255, green: 8'd0, blue: 8'd0};
        endcase
      end
    endcase
    return m;
  endfunction

  // Tone step ROM, all patterns back to back
  function automatic tone_step_t tone_rom(logic [4:0] idx);
    tone_step_t s;
    case (idx)
      5'd0:  s = '{dur: 13'd50,   on: 1'b1};
      5'd1:  s = '{dur: 13'd80,   on: 1'b0};
      5'd2:  s = '{dur: 13'd50,   on: 1'b1};
      5'd3:  s = '{dur: 13'd0,    on: 1'b0};
      5'd4:  s = '{dur: 13'd200,  on: 1'b1};
      5'd5:  s = '{dur: 13'd0,    on: 1'b0};
      5'd6:  s = '{dur: 13'd500,  on: 1'b1};
      5'd7:  s = '{dur: 13'd0,    on: 1'b0};
      5'd8:  s = '{dur: 13'd80,   on: 1'b1};
      5'd9:  s = '{dur: 13'd60,   on: 1'b0};
      5'd10: s = '{dur: 13'd100,  on: 1'b1};
      5'd11: s = '{dur: 13'd60,   on: 1'b0};
      5'd12: s = '{dur: 13'd150,  on: 1'b1};
      5'd13: s = '{dur: 13'd0,    on: 1'b0};
      5'd14: s = '{dur: 13'd200,  on: 1'b1};
      5'd15: s = '{dur: 13'd100,  on: 1'b0};
      5'd16: s = '{dur: 13'd200,  on: 1'b1};
      5'd17: s = '{dur: 13'd100,  on: 1'b0};
      5'd18: s = '{dur: 13'd200,  on: 1'b1};
      5'd19: s = '{dur: 13'd100,  on: 1'b0};
      5'd20: s = '{dur: 13'd200,  on: 1'b1};
      5'd21: s = '{dur: 13'd0,    on: 1'b0};
      5'd22: s = '{dur: 13'd1000, on: 1'b1};
      5'd23: s = '{dur: 13'd0,    on: 1'b0};
      5'd24: s = '{dur: 13'd100,  on: 1'b1};
      5'd25: s = '{dur: 13'd5000, on: 1'b0};
      5'd26: s = '{dur: 13'd200,  on: 1'b1};
      5'd27: s = '{dur: 13'd300,  on: 1'b0};
      default: s = '{dur: 13'd0, on: 1'b0};
    endcase
    return s;
  endfunction

  // First ROM entry of each pattern
  function automatic logic [4:0] tone_start(logic [3:0] pat);
    logic [4:0] r;
    case (pat)
      PAT_ARM:      r = 5'd4;
      PAT_DISARM:   r = 5'd6;
      PAT_TAKEOFF:  r = 5'd8;
      PAT_RTL:      r = 5'd14;
      PAT_LAND:     r = 5'd22;
      PAT_LOWBATT:  r = 5'd24;
      PAT_CRITICAL: r = 5'd26;
      default:      r = 5'd0;
    endcase
    return r;
  endfunction

  // Step count of each pattern
  function automatic logic [3:0] tone_len(logic [3:0] pat);
    logic [3:0] r;
    case (pat)
      PAT_BOOT:                                 r = 4'd4;
      PAT_ARM, PAT_DISARM, PAT_LAND:            r = 4'd2;
      PAT_TAKEOFF:                              r = 4'd6;
      PAT_RTL:                                  r = 4'd8;
      PAT_LOWBATT, PAT_CRITICAL:                r = 4'd2;
      default:                                  r = 4'd0;
    endcase
    return r;
  endfunction

  // Patterns that repeat forever
  function automatic logic tone_loop(logic [3:0] pat);
    return (pat == PAT_LOWBATT) || (pat == PAT_CRITICAL);
  endfunction

endpackage

/* design/slbs_light.sv */
// Status light: colour selection and blink phase tracking.
module slbs_light #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic [TIME_BITS-1:0] now_i,
  input  logic [2:0]           flight_state_i,
  input  logic [1:0]           batt_warn_i,
  output slbs_pkg::rgb_t       rgb_o
);
  import slbs_pkg::*;

  light_mode_t          mode;
  logic [TIME_BITS-1:0] diff;
  logic                 reached;
  logic [TIME_BITS-1:0] pulse_due_q, pulse_due_d;
  logic                 phase_q, phase_d;

  // Pick colour, test due time, toggle phase
  always_comb begin
    mode        = pick_mode(flight_state_i, batt_warn_i);
    diff        = now_i - pulse_due_q;
    reached     = !diff[TIME_BITS-1];
    phase_d     = phase_q;
    pulse_due_d = pulse_due_q;
    rgb_o       = mode.rgb;
    if (mode.blink) begin
      if (reached) begin
        phase_d     = !phase_q;
        pulse_due_d = now_i + TIME_BITS'(mode.half_period);
      end
      if (!phase_d) begin
        rgb_o = '0;
      end
    end
  end

  // Hold blink state between ticks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_due_q <= '0;
      phase_q     <= 1'b0;
    end else if (en_i) begin
      pulse_due_q <= pulse_due_d;
      phase_q     <= phase_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_phase_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(phase_q) && $stable(pulse_due_q))
    else $error("blink state changed without a tick");
`endif

endmodule

/* design/slbs_buzzer.sv */
// Buzzer pattern engine stepping through the tone ROM.
module slbs_buzzer #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic [TIME_BITS-1:0] now_i,
  input  logic                 start_i,
  input  logic [3:0]           pattern_id_i,
  output logic                 level_o
);
  import slbs_pkg::*;

  logic [TIME_BITS-1:0] due_q, due_d;
  logic [3:0]           pat_q, pat_d;
  logic [2:0]           step_q, step_d;
  logic                 level_q, level_d;
  logic [TIME_BITS-1:0] diff;
  logic [3:0]           len;
  logic [3:0]           nxt;
  tone_step_t           ent;

  // Apply start request, then take one step when due
  always_comb begin
    pat_d   = pat_q;
    step_d  = step_q;
    due_d   = due_q;
    level_d = level_q;
    if (start_i) begin
      pat_d  = (pattern_id_i <= PAT_CRITICAL) ? pattern_id_i : PAT_NONE;
      step_d = 3'd0;
      due_d  = now_i;
    end
    diff = now_i - due_d;
    len  = tone_len(pat_d);
    ent  = tone_rom(tone_start(pat_d) + 5'(step_d));
    nxt  = {1'b0, step_d} + 4'd1;
    if ((pat_d != PAT_NONE) && !diff[TIME_BITS-1] && ({1'b0, step_d} < len)) begin
      level_d = ent.on;
      due_d   = now_i + TIME_BITS'(ent.dur);
      step_d  = nxt[2:0];
      if (nxt >= len) begin
        step_d = 3'd0;
        if (!tone_loop(pat_d)) begin
          level_d = 1'b0;
          pat_d   = PAT_NONE;
        end
      end
    end
  end

  assign level_o = level_d;

  // Hold engine state between ticks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      due_q   <= '0;
      pat_q   <= PAT_NONE;
      step_q  <= 3'd0;
      level_q <= 1'b0;
    end else if (en_i) begin
      due_q   <= due_d;
      pat_q   <= pat_d;
      step_q  <= step_d;
      level_q <= level_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_pat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pat_q <= PAT_CRITICAL)
    else $error("active pattern out of range");
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pat_q != PAT_NONE) |-> ({1'b0, step_q} < tone_len(pat_q)))
    else $error("step index beyond pattern length");
`endif

endmodule

/* design/status_light_and_buzzer_sequencer_core.sv */
// Top level: input register, light and buzzer logic, result register.
// A tick waits in the input register until the result register is free to take its result.
// Throughput: one tick per cycle while out_ready_i lets the result register drain;
// the input and result registers pass ticks on; the light and buzzer logic sits between.
// Reset: asynchronous, active low; clears both valid flags, the blink phase and due
// time, and the buzzer engine (no pattern, step 0, silent, due time 0).
module status_light_and_buzzer_sequencer_core #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  slbs_pkg::sl_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output slbs_pkg::sl_out_t out_data_o
);
  import slbs_pkg::*;

  logic                 in_valid_q;
  sl_in_t               in_q;
  logic                 out_valid_q;
  sl_out_t              out_q, out_d;
  logic                 advance;
  logic [TIME_BITS-1:0] now_t;
  rgb_t                 rgb;
  logic                 buzz;

  // Advance the held tick when the result register is free
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign now_t      = TIME_BITS'(in_q.now_ms);

  // Capture input transfers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  slbs_light #(.TIME_BITS(TIME_BITS)) u_light (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (advance),
    .now_i          (now_t),
    .flight_state_i (in_q.flight_state),
    .batt_warn_i    (in_q.batt_warn),
    .rgb_o          (rgb)
  );

  slbs_buzzer #(.TIME_BITS(TIME_BITS)) u_buzzer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (advance),
    .now_i        (now_t),
    .start_i      (in_q.start_pattern),
    .pattern_id_i (in_q.pattern_id),
    .level_o      (buzz)
  );

  // Assemble the result
  always_comb begin
    out_d.red       = rgb.red;
    out_d.green     = rgb.green;
    out_d.blue      = rgb.blue;
    out_d.buzzer_on = buzz;
  end

  // Load the result register; drop valid once the transfer completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed tick left no result");
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled without a full output");
`endif

endmodule
